// ===== hdl/hes_pkg.sv =====
// Package with types, constants and helper functions for the Hamming encoder and checker.
`timescale 1ns / 1ps

package hes_pkg;

    localparam int MAX_CODE_BITS = 64;
    localparam int CW_W          = 64;
    localparam int DATA_W        = 64;
    localparam int LEN_CFG_W     = 6;
    localparam int PAR_W         = 3;
    localparam int SYN_W         = $clog2(MAX_CODE_BITS + 1);
    localparam int POS_W         = $clog2(MAX_CODE_BITS + 1);
    localparam int DATA_LEN_RST  = 4;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    typedef struct packed {
        logic [PAR_W-1:0] parity_count;
        logic [CW_W-1:0]  len_mask;
    } t_cfg;

    function automatic int parity_for(input int n);
        int r;
        r = 1;
        for (int i = 0; i < 7; i++) begin
            if (r < 7 && (1 << r) < n + r + 1) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    function automatic int max_data_len();
        int nmax;
        nmax = 1;
        for (int n = 1; n <= 63; n++) begin
            if (n + parity_for(n) <= MAX_CODE_BITS) begin
                nmax = n;
            end
        end
        return nmax;
    endfunction

    localparam int NMAX = max_data_len();

    function automatic bit is_pow2(input int p);
        return (p & (p - 1)) == 0;
    endfunction

    // Message bit index carried by a non-power-of-two position p.
    function automatic int data_idx(input int p);
        return p - 1 - ($clog2(p + 1));
    endfunction

    // Positions whose 1-based index has bit j set.
    function automatic logic [CW_W-1:0] syn_mask(input int j);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 0; i < CW_W; i++) begin
            m[i] = ((((i + 1) >> j) & 1) != 0);
        end
        return m;
    endfunction

    function automatic logic [CW_W-1:0] len_mask_of(input int len);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 0; i < CW_W; i++) begin
            m[i] = (i < len);
        end
        return m;
    endfunction

    localparam int   PAR_RST = parity_for(DATA_LEN_RST);
    localparam t_cfg CFG_RST = '{
        parity_count: PAR_W'(PAR_RST),
        len_mask:     len_mask_of(DATA_LEN_RST + PAR_RST)
    };

endpackage

// ===== hdl/hamming_encode_and_syndrome.sv =====
// Top level of the Hamming encoder and single-error syndrome checker.
// An accepted request is captured in the input stage, and the output stage then registers its result
// together with the result strobe; the result transfers while that strobe is high.
// Throughput is one transfer per cycle; busy is never raised and results cannot be stalled.
// The data length register resets to four message bits; control state clears on reset.
`timescale 1ns / 1ps

module hamming_encode_and_syndrome (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_req_type,
    input  logic [hes_pkg::DATA_W-1:0]      i_value,
    input  logic                            i_cfg_we,
    input  logic [hes_pkg::LEN_CFG_W-1:0]   i_cfg_wdata,
    output logic                            o_valid,
    output logic [hes_pkg::CW_W-1:0]        o_codeword,
    output logic [hes_pkg::SYN_W-1:0]       o_syndrome,
    output logic                            o_error_found,
    output logic [hes_pkg::PAR_W-1:0]       o_parity_count
);
    import hes_pkg::*;

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic              r_req_type;
    logic [DATA_W-1:0] r_value;
    logic [CW_W-1:0]   w_codeword;
    logic [SYN_W-1:0]  w_syndrome;
    logic              w_error_found;
    logic              r_out_valid;
    logic [CW_W-1:0]   r_codeword;
    logic [SYN_W-1:0]  r_syndrome;
    logic              r_error_found;
    logic [PAR_W-1:0]  r_parity_count;
    logic              w_take;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    hes_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    hes_calc u_calc (
        .i_req_type    (r_req_type),
        .i_value       (r_value),
        .i_cfg         (w_cfg),
        .o_codeword    (w_codeword),
        .o_syndrome    (w_syndrome),
        .o_error_found (w_error_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_take;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req_type <= i_req_type;
            r_value    <= i_value;
        end
        if (r_in_valid) begin
            r_codeword     <= w_codeword;
            r_syndrome     <= w_syndrome;
            r_error_found  <= w_error_found;
            r_parity_count <= w_cfg.parity_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_codeword     = r_codeword;
    assign o_syndrome     = r_syndrome;
    assign o_error_found  = r_error_found;
    assign o_parity_count = r_parity_count;

    a_take_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_in_valid)
        else $error("Accepted request did not enter the input stage.");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("Input stage did not produce a result strobe.");

    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_found == (o_syndrome != '0)))
        else $error("Error flag disagrees with syndrome.");

    a_encode_no_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_codeword != '0) |-> (o_syndrome == '0))
        else $error("Encode result carries a syndrome.");

    a_par_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_parity_count >= PAR_W'(2) && o_parity_count <= PAR_W'(6)))
        else $error("Parity count out of range.");

endmodule

// ===== hdl/hes_cfg.sv =====
// Data length register with derived parity count and codeword position mask.
`timescale 1ns / 1ps

module hes_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hes_pkg::LEN_CFG_W-1:0]  i_cfg_wdata,
    output hes_pkg::t_cfg                  o_cfg
);
    import hes_pkg::*;

    logic [LEN_CFG_W-1:0] w_want;
    logic [LEN_CFG_W-1:0] w_n;
    logic [PAR_W-1:0]     w_r;
    logic [POS_W-1:0]     w_len;
    t_cfg                 r_cfg;
    t_cfg                 n_cfg;

    always_comb begin
        w_want = (i_cfg_wdata == '0) ? LEN_CFG_W'(1) : i_cfg_wdata;
        w_n    = (w_want > LEN_CFG_W'(NMAX)) ? LEN_CFG_W'(NMAX) : w_want;
        w_r    = PAR_W'(1);
        for (int i = 0; i < 7; i++) begin
            if (w_r < PAR_W'(7) &&
                ((POS_W + 1)'(1) << w_r) < ((POS_W + 1)'(w_n) + (POS_W + 1)'(w_r) + 1'b1)) begin
                w_r = w_r + PAR_W'(1);
            end
        end
        w_len = POS_W'(w_n) + POS_W'(w_r);
    end

    always_comb begin
        n_cfg.parity_count = w_r;
        for (int i = 0; i < CW_W; i++) begin
            n_cfg.len_mask[i] = (POS_W'(i) < w_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/hes_calc.sv =====
// Parity trees for codeword generation and syndrome computation.
`timescale 1ns / 1ps

module hes_calc (
    input  logic                        i_req_type,
    input  logic [hes_pkg::DATA_W-1:0]  i_value,
    input  hes_pkg::t_cfg               i_cfg,
    output logic [hes_pkg::CW_W-1:0]    o_codeword,
    output logic [hes_pkg::SYN_W-1:0]   o_syndrome,
    output logic                        o_error_found
);
    import hes_pkg::*;

    logic [CW_W-1:0]  w_scatter;
    logic [CW_W-1:0]  w_data_cw;
    logic [CW_W-1:0]  w_chk_word;
    logic [CW_W-1:0]  w_par;
    logic [CW_W-1:0]  w_enc_cw;
    logic [SYN_W-1:0] w_enc_syn;
    logic [SYN_W-1:0] w_chk_syn;

    for (genvar g = 0; g < CW_W; g++) begin : g_pos
        localparam int P = g + 1;
        if (is_pow2(P)) begin : g_par
            assign w_scatter[g] = 1'b0;
            assign w_par[g]     = w_enc_syn[$clog2(P)];
        end else begin : g_dat
            assign w_scatter[g] = i_value[data_idx(P)];
            assign w_par[g]     = 1'b0;
        end
    end

    assign w_data_cw  = w_scatter & i_cfg.len_mask;
    assign w_chk_word = i_value & i_cfg.len_mask;

    for (genvar j = 0; j < SYN_W; j++) begin : g_syn
        localparam logic [CW_W-1:0] M = syn_mask(j);
        assign w_enc_syn[j] = ^(w_data_cw & M);
        assign w_chk_syn[j] = ^(w_chk_word & M);
    end

    assign w_enc_cw = w_data_cw | (w_par & i_cfg.len_mask);

    always_comb begin
        if (i_req_type == REQ_CHECK) begin
            o_codeword    = '0;
            o_syndrome    = w_chk_syn;
            o_error_found = |w_chk_syn;
        end else begin
            o_codeword    = w_enc_cw;
            o_syndrome    = '0;
            o_error_found = 1'b0;
        end
    end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Hamming encoder and single-error syndrome checker.
`timescale 1ns / 1ps

module tb;

    import hes_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        ENT_REQ,
        ENT_LEN_WRITE,
        ENT_DRAIN
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind           kind;
        logic                 req_type;
        logic [DATA_W-1:0]    value;
        logic [LEN_CFG_W-1:0] len;
        logic [6:0]           gap_pct;
    } t_stim_entry;

    typedef struct packed {
        logic [CW_W-1:0]  codeword;
        logic [SYN_W-1:0] syndrome;
        logic             error_found;
        logic [PAR_W-1:0] parity_count;
    } t_hamming_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_req_type = REQ_ENCODE;
    logic [DATA_W-1:0]    i_value = '0;
    logic                 i_cfg_we = 1'b0;
    logic [LEN_CFG_W-1:0] i_cfg_wdata = '0;
    logic                 o_valid;
    logic [CW_W-1:0]      o_codeword;
    logic [SYN_W-1:0]     o_syndrome;
    logic                 o_error_found;
    logic [PAR_W-1:0]     o_parity_count;

    t_stim_entry     pending_stim[$];
    t_hamming_result expected_results[$];

    logic [LEN_CFG_W-1:0] active_len = LEN_CFG_W'(DATA_LEN_RST);
    logic [LEN_CFG_W-1:0] plan_len = LEN_CFG_W'(DATA_LEN_RST);
    int                   plan_gap = 28;
    int                   n_fail = 0;
    int                   n_encodes = 0;
    int                   n_checks = 0;
    int                   n_flagged = 0;
    int                   n_len_writes = 0;
    int                   stall_cycles = 0;

    hamming_encode_and_syndrome i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_codeword     (o_codeword),
        .o_syndrome     (o_syndrome),
        .o_error_found  (o_error_found),
        .o_parity_count (o_parity_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned check_bits(input int unsigned n);
        int unsigned r;
        r = 1;
        while (r < 7 && (1 << r) < n + r + 1) begin
            r++;
        end
        return r;
    endfunction

    function automatic int unsigned msg_bits(input logic [LEN_CFG_W-1:0] len);
        int unsigned want;
        int unsigned nmax;
        want = (len == 0) ? 1 : int'(len);
        nmax = 1;
        for (int unsigned n = 1; n <= 63; n++) begin
            if (n + check_bits(n) <= MAX_CODE_BITS) begin
                nmax = n;
            end
        end
        return (want > nmax) ? nmax : want;
    endfunction

    function automatic int unsigned position_xor(input logic [CW_W-1:0] word,
                                                 input int unsigned width);
        int unsigned acc;
        acc = 0;
        for (int unsigned pos = 1; pos <= width; pos++) begin
            if (word[pos-1]) begin
                acc = acc ^ pos;
            end
        end
        return acc;
    endfunction

    function automatic t_hamming_result predict_result(input logic req_type,
                                                       input logic [DATA_W-1:0] value,
                                                       input logic [LEN_CFG_W-1:0] len);
        t_hamming_result res;
        int unsigned     n;
        int unsigned     r;
        int unsigned     width;
        int unsigned     k;
        int unsigned     syn;
        n = msg_bits(len);
        r = check_bits(n);
        width = n + r;
        res = '0;
        if (req_type == REQ_ENCODE) begin
            k = 0;
            for (int unsigned pos = 1; pos <= width; pos++) begin
                if ((pos & (pos - 1)) != 0) begin
                    res.codeword[pos-1] = value[k];
                    k++;
                end
            end
            syn = position_xor(res.codeword, width);
            for (int unsigned pos = 1; pos <= width; pos = pos << 1) begin
                if ((syn & pos) != 0) begin
                    res.codeword[pos-1] = 1'b1;
                end
            end
        end else begin
            syn = position_xor(value, width);
            res.syndrome = SYN_W'(syn);
            res.error_found = (syn != 0);
        end
        res.parity_count = PAR_W'(r);
        return res;
    endfunction

    task automatic queue_req(input logic req_type, input logic [DATA_W-1:0] value);
        t_stim_entry e;
        e = '0;
        e.kind = ENT_REQ;
        e.req_type = req_type;
        e.value = value;
        e.gap_pct = 7'(plan_gap);
        pending_stim.push_back(e);
    endtask

    task automatic queue_len(input logic [LEN_CFG_W-1:0] len);
        t_stim_entry e;
        e = '0;
        e.kind = ENT_LEN_WRITE;
        e.len = len;
        pending_stim.push_back(e);
        plan_len = len;
    endtask

    task automatic queue_drain();
        t_stim_entry e;
        e = '0;
        e.kind = ENT_DRAIN;
        pending_stim.push_back(e);
    endtask

    // Most checks carry a valid codeword with zero, one or two flipped positions.
    task automatic queue_random_item();
        t_hamming_result   enc;
        logic [DATA_W-1:0] data;
        logic [CW_W-1:0]   word;
        int unsigned       n;
        int unsigned       width;
        int unsigned       pick;
        int unsigned       a;
        int unsigned       b;
        data = {$urandom, $urandom};
        n = msg_bits(plan_len);
        width = n + check_bits(n);
        pick = $urandom_range(99);
        if (pick < 40) begin
            queue_req(REQ_ENCODE, data);
        end else if (pick < 90) begin
            enc = predict_result(REQ_ENCODE, data, plan_len);
            word = enc.codeword;
            pick = $urandom_range(99);
            if (pick < 45) begin
                a = $urandom_range(width - 1);
                word[a] = ~word[a];
            end else if (pick < 60) begin
                a = $urandom_range(width - 1);
                b = (a + 1 + $urandom_range(width - 2)) % width;
                word[a] = ~word[a];
                word[b] = ~word[b];
            end else if (pick < 75 && width < CW_W) begin
                word = word | ({$urandom, $urandom} & ~len_mask_of(width));
            end
            queue_req(REQ_CHECK, word);
        end else begin
            queue_req(REQ_CHECK, data);
        end
    endtask

    always @(posedge i_clk) begin : request_driver
        t_stim_entry head;
        logic        start_nxt;
        logic        we_nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_result(i_req_type, i_value, active_len));
                if (i_req_type == REQ_ENCODE) begin
                    n_encodes++;
                end else begin
                    n_checks++;
                end
            end
            start_nxt = start && busy;
            we_nxt = 1'b0;
            if (!start_nxt && pending_stim.size() > 0) begin
                head = pending_stim[0];
                case (head.kind)
                    ENT_REQ: begin
                        if ($urandom_range(99) >= head.gap_pct) begin
                            start_nxt = 1'b1;
                            i_req_type <= head.req_type;
                            i_value <= head.value;
                            void'(pending_stim.pop_front());
                        end
                    end
                    ENT_LEN_WRITE: begin
                        if (expected_results.size() == 0) begin
                            we_nxt = 1'b1;
                            i_cfg_wdata <= head.len;
                            active_len = head.len;
                            n_len_writes++;
                            void'(pending_stim.pop_front());
                        end
                    end
                    default: begin
                        if (expected_results.size() == 0) begin
                            void'(pending_stim.pop_front());
                        end
                    end
                endcase
            end
            start <= start_nxt;
            i_cfg_we <= we_nxt;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_hamming_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                n_fail++;
                $display("%0t: result transfer with no request outstanding", $time);
            end else begin
                want = expected_results.pop_front();
                if (want.error_found) begin
                    n_flagged++;
                end
                if (o_codeword !== want.codeword) begin
                    n_fail++;
                    $display("%0t: codeword expected %h, got %h", $time,
                             want.codeword, o_codeword);
                end
                if (o_syndrome !== want.syndrome) begin
                    n_fail++;
                    $display("%0t: syndrome expected %0d, got %0d", $time,
                             want.syndrome, o_syndrome);
                end
                if (o_error_found !== want.error_found) begin
                    n_fail++;
                    $display("%0t: error_found expected %b, got %b", $time,
                             want.error_found, o_error_found);
                end
                if (o_parity_count !== want.parity_count) begin
                    n_fail++;
                    $display("%0t: parity_count expected %0d, got %0d", $time,
                             want.parity_count, o_parity_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || i_cfg_we) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : stimulus
        logic [LEN_CFG_W-1:0] len;

        // The reset length of four message bits is exercised before any write.
        queue_req(REQ_ENCODE, 64'h0);
        queue_req(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_ENCODE, 64'hB);
        queue_req(REQ_CHECK, 64'h0);
        queue_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_CHECK, 64'h4);
        queue_len(6'd0);
        queue_req(REQ_ENCODE, 64'h1);
        queue_req(REQ_CHECK, 64'h7);
        queue_req(REQ_CHECK, 64'h2);
        queue_len(6'd57);
        queue_req(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_ENCODE, 64'h0155_AA55_F00F_3CC3);
        queue_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_CHECK, 64'h8000_0000_0000_0000);
        queue_req(REQ_CHECK, 64'h4000_0000_0000_0000);
        queue_len(6'd63);
        queue_req(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(REQ_CHECK, 64'h4000_0000_0000_0000);
        queue_len(6'd1);
        queue_req(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFF8);
        queue_len(6'd26);
        queue_req(REQ_ENCODE, 64'h03FF_FFFF);
        queue_len(6'd27);
        queue_req(REQ_ENCODE, 64'h07FF_FFFF);

        for (int ph = 0; ph < 20; ph++) begin
            case (ph)
                0: len = 6'd57;
                1: len = 6'd1;
                2: len = 6'd0;
                3: len = 6'd63;
                default: len = LEN_CFG_W'($urandom_range(63));
            endcase
            plan_gap = (ph == 5) ? 0 : 28;
            queue_len(len);
            for (int i = 0; i < 97; i++) begin
                if (ph % 4 == 2 && i == 48) begin
                    queue_drain();
                end
                queue_random_item();
            end
        end

        while (pending_stim.size() != 0 || start || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_fail++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end

        $display("Ran %0d encodes and %0d checks over %0d data length settings.",
                 n_encodes, n_checks, n_len_writes);
        $display("%0d checks reported a nonzero syndrome.", n_flagged);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== hamming_encode_and_syndrome.f =====
hdl/hes_pkg.sv
hdl/hes_cfg.sv
hdl/hes_calc.sv
hdl/hamming_encode_and_syndrome.sv
bench/tb.sv
